### sv/ppt_pkg.sv
// Package for the pedal plausibility torque gate.
// Holds register indexes, reset values, fixed-point constants and the flag struct.
// No dependencies.
package ppt_pkg;

  typedef enum logic [2:0] {
    REG_APPS_TRAVEL_LIMIT  = 3'd0,
    REG_APPS_TIME_LIMIT    = 3'd1,
    REG_BSE_TIME_LIMIT     = 3'd2,
    REG_BPPC_TRIGGER_LEVEL = 3'd3,
    REG_BPPC_RELEASE_LEVEL = 3'd4,
    REG_TORQUE_FULL        = 3'd5,
    REG_TORQUE_SLOW        = 3'd6,
    REG_RAMP_SLOPE         = 3'd7
  } cfg_reg_t;

  localparam logic [7:0]  RST_APPS_TRAVEL_LIMIT  = 8'd25;
  localparam logic [31:0] RST_APPS_TIME_LIMIT    = 32'd100000;
  localparam logic [31:0] RST_BSE_TIME_LIMIT     = 32'd100000;
  localparam logic [7:0]  RST_BPPC_TRIGGER_LEVEL = 8'd64;
  localparam logic [7:0]  RST_BPPC_RELEASE_LEVEL = 8'd13;
  localparam logic [15:0] RST_TORQUE_FULL        = 16'd1000;
  localparam logic [15:0] RST_TORQUE_SLOW        = 16'd500;
  localparam logic [15:0] RST_RAMP_SLOPE         = 16'd1000;

  localparam logic [7:0]  LEVEL_LOW  = 8'd0;
  localparam logic [7:0]  LEVEL_HIGH = 8'd255;

  localparam logic [31:0] TIMER_MAX      = 32'hFFFF_FFFF;
  localparam logic [31:0] DECAY_FLOOR_US = 32'd1000;

  // floor(p / 254) for p below 2^24 equals (p * TRAVEL_RECIP) >> TRAVEL_SHIFT.
  localparam int          TRAVEL_SHIFT = 32;
  localparam logic [24:0] TRAVEL_RECIP = 25'd16909321;

  // floor(s / 1e6) equals ((s >> 6) * SLOPE_RECIP) >> SLOPE_SHIFT for 32-bit s.
  localparam int          SLOPE_PRESHIFT = 6;
  localparam int          SLOPE_SHIFT    = 40;
  localparam logic [26:0] SLOPE_RECIP    = 27'd70368745;

  typedef struct packed {
    logic enable;
    logic apps;
    logic bse;
    logic bppc;
    logic ramp;
  } flags_t;

endpackage

### sv/pedal_plausibility_torque_gate.sv
// Pedal plausibility torque gate: top level, four register stages.
// A beat accepted into the input register moves through the stage 1 and stage 2 registers to the output register.
// Throughput: one beat per cycle while out_ready holds no beat back; fault timers and latches close their loop in the
// first stage and last_torque in the fourth, so no beat waits on another.
// Reset (rst, synchronous): pipeline empty, state zero, registers to defaults.
// Depends on ppt_pkg.
module pedal_plausibility_torque_gate #(
  parameter int RAMP_SPEED = 100,
  parameter int APPS_DECAY = 1,
  parameter int BSE_DECAY  = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  accel_level_a,
  input  logic [7:0]  accel_level_b,
  input  logic [7:0]  brake_level,
  input  logic        brake_switch,
  input  logic        slow_gear,
  input  logic signed [15:0] shaft_rpm,
  input  logic        active,
  input  logic [15:0] elapsed_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] torque_cmd,
  output logic        direction_cmd,
  output logic        drive_enable,
  output logic        apps_fault,
  output logic        bse_fault,
  output logic        bppc_fault
);

  localparam logic signed [15:0] SOFT_SPEED = 16'(RAMP_SPEED);
  localparam logic [31:0] APPS_K = 32'(APPS_DECAY);
  localparam logic [31:0] BSE_K  = 32'(BSE_DECAY);

  // Configuration registers.
  logic [7:0]  apps_travel_limit;
  logic [31:0] apps_time_limit;
  logic [31:0] bse_time_limit;
  logic [7:0]  bppc_trigger_level;
  logic [7:0]  bppc_release_level;
  logic [15:0] torque_full;
  logic [15:0] torque_slow;
  logic [15:0] ramp_slope;

  always_ff @(posedge clk) begin
    if (rst) begin
      apps_travel_limit  <= ppt_pkg::RST_APPS_TRAVEL_LIMIT;
      apps_time_limit    <= ppt_pkg::RST_APPS_TIME_LIMIT;
      bse_time_limit     <= ppt_pkg::RST_BSE_TIME_LIMIT;
      bppc_trigger_level <= ppt_pkg::RST_BPPC_TRIGGER_LEVEL;
      bppc_release_level <= ppt_pkg::RST_BPPC_RELEASE_LEVEL;
      torque_full        <= ppt_pkg::RST_TORQUE_FULL;
      torque_slow        <= ppt_pkg::RST_TORQUE_SLOW;
      ramp_slope         <= ppt_pkg::RST_RAMP_SLOPE;
    end else if (cfg_we) begin
      unique case (ppt_pkg::cfg_reg_t'(cfg_index))
        ppt_pkg::REG_APPS_TRAVEL_LIMIT:  apps_travel_limit  <= cfg_data[7:0];
        ppt_pkg::REG_APPS_TIME_LIMIT:    apps_time_limit    <= cfg_data;
        ppt_pkg::REG_BSE_TIME_LIMIT:     bse_time_limit     <= cfg_data;
        ppt_pkg::REG_BPPC_TRIGGER_LEVEL: bppc_trigger_level <= cfg_data[7:0];
        ppt_pkg::REG_BPPC_RELEASE_LEVEL: bppc_release_level <= cfg_data[7:0];
        ppt_pkg::REG_TORQUE_FULL:        torque_full        <= cfg_data[15:0];
        ppt_pkg::REG_TORQUE_SLOW:        torque_slow        <= cfg_data[15:0];
        ppt_pkg::REG_RAMP_SLOPE:         ramp_slope         <= cfg_data[15:0];
      endcase
    end
  end

  // Stage valids and flow control.
  logic s0_valid, s1_valid, s2_valid;
  logic out_free, s2_free, s1_free, s0_free;
  logic s0_fire, s1_fire, s2_fire;

  assign out_free = !out_valid || out_ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s0_free  = !s0_valid || s1_free;
  assign in_ready = s0_free;
  assign s0_fire  = s0_valid && s1_free;
  assign s1_fire  = s1_valid && s2_free;
  assign s2_fire  = s2_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s0_valid <= 1'b1;
      end else if (s0_fire) begin
        s0_valid <= 1'b0;
      end
      if (s0_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        s2_valid <= 1'b1;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end
      if (s2_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stage 0: input register.
  logic [7:0]  la, lb, lbrk;
  logic        sw, slow, act;
  logic signed [15:0] speed;
  logic [15:0] dt;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      la    <= accel_level_a;
      lb    <= accel_level_b;
      lbrk  <= brake_level;
      sw    <= brake_switch;
      slow  <= slow_gear;
      speed <= shaft_rpm;
      act   <= active;
      dt    <= elapsed_us;
    end
  end

  // Plausibility state.
  logic [31:0] apps_timer, apps_timer_next;
  logic [31:0] bse_timer, bse_timer_next;
  logic        apps_latched, apps_latched_next;
  logic        bse_latched, bse_latched_next;
  logic        bppc_latched, bppc_latched_next;

  logic [7:0]  lmin, travel, diff, travel_chk;
  logic        apps_cond, bse_cond, apps_zero, bse_zero, bppc_zero;
  logic [32:0] apps_sum, bse_sum;
  logic [31:0] apps_dec, bse_dec;

  always_comb begin
    lmin      = (la < lb) ? la : lb;
    travel    = (lmin == ppt_pkg::LEVEL_LOW) ? 8'd0 : lmin - 8'd1;
    diff      = (la > lb) ? la - lb : lb - la;
    apps_cond = la == ppt_pkg::LEVEL_LOW || la == ppt_pkg::LEVEL_HIGH ||
                lb == ppt_pkg::LEVEL_LOW || lb == ppt_pkg::LEVEL_HIGH ||
                diff > apps_travel_limit;
    bse_cond  = lbrk == ppt_pkg::LEVEL_LOW || lbrk == ppt_pkg::LEVEL_HIGH;
    apps_sum  = {1'b0, apps_timer} + {17'd0, dt};
    bse_sum   = {1'b0, bse_timer} + {17'd0, dt};
    apps_dec  = APPS_K * {16'd0, dt};
    bse_dec   = BSE_K * {16'd0, dt};

    apps_timer_next   = apps_timer;
    apps_latched_next = apps_latched;
    bse_timer_next    = bse_timer;
    bse_latched_next  = bse_latched;
    bppc_latched_next = bppc_latched;
    apps_zero = 1'b0;
    bse_zero  = 1'b0;
    bppc_zero = 1'b0;

    if (apps_cond) begin
      if (apps_timer > apps_time_limit) begin
        apps_latched_next = 1'b1;
        apps_zero = 1'b1;
      end else begin
        apps_timer_next = apps_sum[32] ? ppt_pkg::TIMER_MAX : apps_sum[31:0];
      end
    end else if (apps_timer > ppt_pkg::DECAY_FLOOR_US) begin
      apps_timer_next = (apps_dec >= apps_timer) ? 32'd0 : apps_timer - apps_dec;
      apps_zero = 1'b1;
    end else begin
      apps_latched_next = 1'b0;
    end

    if (!apps_zero) begin
      if (bse_cond) begin
        if (bse_timer > bse_time_limit) begin
          bse_latched_next = 1'b1;
          bse_zero = 1'b1;
        end else begin
          bse_timer_next = bse_sum[32] ? ppt_pkg::TIMER_MAX : bse_sum[31:0];
        end
      end else if (bse_timer > ppt_pkg::DECAY_FLOOR_US) begin
        bse_timer_next = (bse_dec >= bse_timer) ? 32'd0 : bse_timer - bse_dec;
        bse_zero = 1'b1;
      end else begin
        bse_latched_next = 1'b0;
      end
    end

    if (!apps_zero && !bse_zero) begin
      if (bppc_latched) begin
        if (travel > bppc_release_level) begin
          bppc_zero = 1'b1;
        end else begin
          bppc_latched_next = 1'b0;
        end
      end else if (sw && travel > bppc_trigger_level) begin
        bppc_latched_next = 1'b1;
        bppc_zero = 1'b1;
      end
    end

    travel_chk = (apps_zero || bse_zero || bppc_zero) ? 8'd0 : travel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      apps_timer   <= 32'd0;
      bse_timer    <= 32'd0;
      apps_latched <= 1'b0;
      bse_latched  <= 1'b0;
      bppc_latched <= 1'b0;
    end else if (s0_fire) begin
      apps_timer   <= apps_timer_next;
      bse_timer    <= bse_timer_next;
      apps_latched <= apps_latched_next;
      bse_latched  <= bse_latched_next;
      bppc_latched <= bppc_latched_next;
    end
  end

  // Stage 1: raw products.
  logic [23:0] s1_prod;
  logic [31:0] s1_slope_dt;
  ppt_pkg::flags_t s1_flags, s0_flags;

  always_comb begin
    s0_flags.apps   = apps_latched_next;
    s0_flags.bse    = bse_latched_next;
    s0_flags.bppc   = bppc_latched_next;
    s0_flags.enable = act && !apps_latched_next && !bse_latched_next &&
                      !bppc_latched_next;
    s0_flags.ramp   = speed < SOFT_SPEED;
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      s1_prod     <= travel_chk * (slow ? torque_slow : torque_full);
      s1_slope_dt <= ramp_slope * dt;
      s1_flags    <= s0_flags;
    end
  end

  // Stage 2: constant divisions by reciprocal multiplication.
  logic [48:0] travel_q;
  logic [52:0] slope_q;
  logic [25:0] slope_pre;
  logic [15:0] s2_torque;
  logic [12:0] s2_inc;
  ppt_pkg::flags_t s2_flags;

  assign slope_pre = s1_slope_dt[31:ppt_pkg::SLOPE_PRESHIFT];
  assign travel_q  = s1_prod * ppt_pkg::TRAVEL_RECIP;
  assign slope_q   = slope_pre * ppt_pkg::SLOPE_RECIP;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_torque <= travel_q[ppt_pkg::TRAVEL_SHIFT +: 16];
      s2_inc    <= slope_q[ppt_pkg::SLOPE_SHIFT +: 13];
      s2_flags  <= s1_flags;
    end
  end

  // Stage 3: ramp limit and output register.
  logic [15:0] last_torque, last_torque_next;
  logic [16:0] lim_sum;
  logic [15:0] lim;

  always_comb begin
    lim_sum = {1'b0, last_torque} + {4'd0, s2_inc};
    lim = (lim_sum > {1'b0, torque_full}) ? torque_full : lim_sum[15:0];
    last_torque_next = s2_torque;
    if (s2_flags.ramp && s2_torque > lim) begin
      last_torque_next = lim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_torque <= 16'd0;
    end else if (s2_fire) begin
      last_torque <= last_torque_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      torque_cmd    <= s2_flags.enable ? last_torque_next : 16'd0;
      direction_cmd <= s2_flags.enable;
      drive_enable  <= s2_flags.enable;
      apps_fault    <= s2_flags.apps;
      bse_fault     <= s2_flags.bse;
      bppc_fault    <= s2_flags.bppc;
    end
  end

endmodule

### sv/ppt_checker.sv
// Port-level checker for the pedal plausibility torque gate, with its bind.
// Depends only on the top level's ports.
module ppt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] torque_cmd,
  input logic        direction_cmd,
  input logic        drive_enable,
  input logic        apps_fault,
  input logic        bse_fault,
  input logic        bppc_fault
);

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_enable |-> torque_cmd == 16'd0 && !direction_cmd)
    else $error("Disabled beat carries torque or direction.");

  a_dir_follows_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> direction_cmd == drive_enable)
    else $error("Direction differs from drive enable.");

  a_enable_no_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_enable |-> !apps_fault && !bse_fault && !bppc_fault)
    else $error("Drive enabled with a latched fault.");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("Output valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(torque_cmd))
    else $error("Stalled output beat dropped or changed.");

endmodule

bind pedal_plausibility_torque_gate ppt_checker u_ppt_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .torque_cmd(torque_cmd),
  .direction_cmd(direction_cmd),
  .drive_enable(drive_enable),
  .apps_fault(apps_fault),
  .bse_fault(bse_fault),
  .bppc_fault(bppc_fault)
);

### tb/testbench.sv
// Testbench for pedal_plausibility_torque_gate: a directed table of control ticks, then
// random driving scenarios under several register settings, checked beat by beat.
// Depends on ppt_pkg and the pedal_plausibility_torque_gate RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int RAMP_SPEED_RPM = 100;
  localparam int APPS_DECAY_RATE = 1;
  localparam int BSE_DECAY_RATE = 1;
  localparam int TRAVEL_FULL = 254;
  localparam longint unsigned US_PER_S = 1000000;
  localparam int TICKS_PER_PHASE = 200;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [7:0]        level_a;
    logic [7:0]        level_b;
    logic [7:0]        brake;
    logic              sw;
    logic              slow;
    logic signed [15:0] speed;
    logic              act;
    logic [15:0]       dt;
  } tick_t;

  typedef struct packed {
    logic [15:0] torque;
    logic        fwd;
    logic        en;
    logic        apps;
    logic        bse;
    logic        bppc;
  } verdict_t;

  typedef struct packed {
    tick_t    stim;
    logic     known;
    verdict_t want;
  } row_t;

  typedef enum int {
    SC_CRUISE,
    SC_APPS_SPLIT,
    SC_SENSOR_OUT,
    SC_BRAKE_OVERLAP,
    SC_NOISE
  } scenario_t;

  localparam verdict_t NO_VERDICT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  ppt_pkg::cfg_reg_t cfg_index = ppt_pkg::REG_APPS_TRAVEL_LIMIT;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] accel_level_a = '0;
  logic [7:0] accel_level_b = '0;
  logic [7:0] brake_level = '0;
  logic brake_switch = 1'b0;
  logic slow_gear = 1'b0;
  logic signed [15:0] shaft_rpm = '0;
  logic active = 1'b0;
  logic [15:0] elapsed_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] torque_cmd;
  logic direction_cmd;
  logic drive_enable;
  logic apps_fault;
  logic bse_fault;
  logic bppc_fault;

  // Register mirror and block state as the predictor sees them.
  logic [7:0]  lim_split = ppt_pkg::RST_APPS_TRAVEL_LIMIT;
  logic [31:0] apps_limit_us = ppt_pkg::RST_APPS_TIME_LIMIT;
  logic [31:0] bse_limit_us = ppt_pkg::RST_BSE_TIME_LIMIT;
  logic [7:0]  trig_level = ppt_pkg::RST_BPPC_TRIGGER_LEVEL;
  logic [7:0]  rel_level = ppt_pkg::RST_BPPC_RELEASE_LEVEL;
  logic [15:0] full_torque = ppt_pkg::RST_TORQUE_FULL;
  logic [15:0] slow_torque = ppt_pkg::RST_TORQUE_SLOW;
  logic [15:0] ramp_slope = ppt_pkg::RST_RAMP_SLOPE;
  logic [31:0] apps_fault_us = '0;
  logic [31:0] bse_fault_us = '0;
  logic apps_held = 1'b0;
  logic bse_held = 1'b0;
  logic bppc_held = 1'b0;
  logic [15:0] prev_torque = '0;

  verdict_t expected[$];
  row_t script[$];
  logic calm = 1'b0;
  int errors = 0;
  int ticks_sent = 0;
  int settings_used = 1;
  int apps_beats = 0;
  int bse_beats = 0;
  int bppc_beats = 0;
  int cycles = 0;

  pedal_plausibility_torque_gate #(
    .RAMP_SPEED(RAMP_SPEED_RPM),
    .APPS_DECAY(APPS_DECAY_RATE),
    .BSE_DECAY(BSE_DECAY_RATE)
  ) DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic tick_t tick_of(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] brk, input logic sw,
                                    input logic slow, input logic [15:0] speed,
                                    input logic act, input logic [15:0] dt);
    tick_t t;
    t = {a, b, brk, sw, slow, speed, act, dt};
    return t;
  endfunction

  function automatic verdict_t verdict_of(input logic [15:0] torque, input logic fwd,
                                          input logic en, input logic apps,
                                          input logic bse, input logic bppc);
    verdict_t v;
    v = {torque, fwd, en, apps, bse, bppc};
    return v;
  endfunction

  task automatic age_fault_timer(input logic fault, inout logic [31:0] elapsed,
                                 inout logic held, input logic [31:0] limit,
                                 input int decay_rate, input logic [15:0] dt,
                                 output logic blank);
    logic [32:0] sum;
    longint unsigned drop;
    blank = 1'b0;
    if (fault) begin
      if (elapsed > limit) begin
        held = 1'b1;
        blank = 1'b1;
      end else begin
        sum = {1'b0, elapsed} + {17'd0, dt};
        elapsed = sum[32] ? ppt_pkg::TIMER_MAX : sum[31:0];
      end
    end else if (elapsed > ppt_pkg::DECAY_FLOOR_US) begin
      drop = decay_rate;
      drop = drop * dt;
      elapsed = (drop >= elapsed) ? 32'd0 : elapsed - drop[31:0];
      blank = 1'b1;
    end else begin
      held = 1'b0;
    end
  endtask

  task automatic predict_tick(input tick_t t, output verdict_t v);
    int ta;
    int tb;
    int lowest;
    int spread;
    logic [7:0] travel;
    logic split_bad;
    logic brake_bad;
    logic blank;
    logic en;
    logic [15:0] tmax;
    longint unsigned torque;
    longint unsigned ceiling;
    longint unsigned step_up;
    ta = int'(t.level_a) - 1;
    tb = int'(t.level_b) - 1;
    lowest = (ta < tb) ? ta : tb;
    spread = (ta > tb) ? ta - tb : tb - ta;
    travel = (lowest < 0) ? 8'd0 : lowest[7:0];
    split_bad = t.level_a == ppt_pkg::LEVEL_LOW || t.level_a == ppt_pkg::LEVEL_HIGH ||
                t.level_b == ppt_pkg::LEVEL_LOW || t.level_b == ppt_pkg::LEVEL_HIGH ||
                spread > int'(lim_split);
    brake_bad = t.brake == ppt_pkg::LEVEL_LOW || t.brake == ppt_pkg::LEVEL_HIGH;
    age_fault_timer(split_bad, apps_fault_us, apps_held, apps_limit_us, APPS_DECAY_RATE,
                    t.dt, blank);
    if (!blank) begin
      age_fault_timer(brake_bad, bse_fault_us, bse_held, bse_limit_us, BSE_DECAY_RATE,
                      t.dt, blank);
      if (!blank) begin
        if (bppc_held) begin
          if (travel > rel_level) blank = 1'b1;
          else bppc_held = 1'b0;
        end else if (t.sw && travel > trig_level) begin
          bppc_held = 1'b1;
          blank = 1'b1;
        end
      end
    end
    if (blank) travel = 8'd0;
    tmax = t.slow ? slow_torque : full_torque;
    torque = travel;
    torque = torque * tmax / TRAVEL_FULL;
    if ($signed(t.speed) < RAMP_SPEED_RPM) begin
      step_up = ramp_slope;
      step_up = step_up * t.dt / US_PER_S;
      ceiling = prev_torque;
      ceiling = ceiling + step_up;
      if (ceiling > full_torque) ceiling = full_torque;
      if (torque > ceiling) torque = ceiling;
    end
    prev_torque = torque[15:0];
    en = t.act && !apps_held && !bse_held && !bppc_held;
    v = verdict_of(en ? torque[15:0] : 16'd0, en, en, apps_held, bse_held, bppc_held);
  endtask

  task automatic send_tick(input tick_t t, input logic known, input verdict_t want);
    int gap;
    verdict_t predicted;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {accel_level_a, accel_level_b, brake_level, brake_switch, slow_gear, shaft_rpm,
     active, elapsed_us} <= t;
    do @(posedge clk); while (!in_ready);
    predict_tick(t, predicted);
    expected.push_back(known ? want : predicted);
    ticks_sent++;
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (expected.size() != 0) @(posedge clk);
  endtask

  // The block must be idle: call only after drain_results.
  task automatic write_reg(input ppt_pkg::cfg_reg_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      ppt_pkg::REG_APPS_TRAVEL_LIMIT: lim_split = value[7:0];
      ppt_pkg::REG_APPS_TIME_LIMIT: apps_limit_us = value;
      ppt_pkg::REG_BSE_TIME_LIMIT: bse_limit_us = value;
      ppt_pkg::REG_BPPC_TRIGGER_LEVEL: trig_level = value[7:0];
      ppt_pkg::REG_BPPC_RELEASE_LEVEL: rel_level = value[7:0];
      ppt_pkg::REG_TORQUE_FULL: full_torque = value[15:0];
      ppt_pkg::REG_TORQUE_SLOW: slow_torque = value[15:0];
      ppt_pkg::REG_RAMP_SLOPE: ramp_slope = value[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] split, input logic [31:0] apps_us,
                               input logic [31:0] bse_us, input logic [31:0] trig,
                               input logic [31:0] rel, input logic [31:0] full,
                               input logic [31:0] slow, input logic [31:0] slope);
    write_reg(ppt_pkg::REG_APPS_TRAVEL_LIMIT, split);
    write_reg(ppt_pkg::REG_APPS_TIME_LIMIT, apps_us);
    write_reg(ppt_pkg::REG_BSE_TIME_LIMIT, bse_us);
    write_reg(ppt_pkg::REG_BPPC_TRIGGER_LEVEL, trig);
    write_reg(ppt_pkg::REG_BPPC_RELEASE_LEVEL, rel);
    write_reg(ppt_pkg::REG_TORQUE_FULL, full);
    write_reg(ppt_pkg::REG_TORQUE_SLOW, slow);
    write_reg(ppt_pkg::REG_RAMP_SLOPE, slope);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic tick_t draw_tick(input scenario_t sc);
    tick_t t;
    int p;
    int q;
    int sp;
    int which;
    logic [7:0] lvl;
    logic [63:0] raw;
    p = $urandom_range(1, 254);
    q = p + int'($urandom_range(0, 24)) - 12;
    if (q < 1) q = 1;
    if (q > 254) q = 254;
    sp = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 199)) - 100
                                     : int'($urandom & 32'hFFFF);
    t.level_a = p[7:0];
    t.level_b = q[7:0];
    t.brake = 8'($urandom_range(1, 254));
    t.sw = 1'($urandom_range(0, 1));
    t.slow = 1'($urandom_range(0, 1));
    t.speed = sp[15:0];
    t.act = ($urandom_range(0, 15) != 0);
    t.dt = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5000));
    case (sc)
      SC_CRUISE: t.sw = ($urandom_range(0, 7) == 0);
      SC_APPS_SPLIT: t.level_b = 8'($urandom_range(1, 254));
      SC_SENSOR_OUT: begin
        lvl = ($urandom_range(0, 1) != 0) ? ppt_pkg::LEVEL_HIGH : ppt_pkg::LEVEL_LOW;
        which = $urandom_range(0, 2);
        if (which == 0) t.level_a = lvl;
        else if (which == 1) t.level_b = lvl;
        else t.brake = lvl;
      end
      SC_BRAKE_OVERLAP: begin
        p = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 20) : $urandom_range(60, 254);
        t.level_a = p[7:0];
        t.level_b = p[7:0];
        t.sw = ($urandom_range(0, 3) != 0);
      end
      default: begin
        raw = {$urandom, $urandom};
        t = raw[$bits(tick_t)-1:0];
      end
    endcase
    return t;
  endfunction

  task automatic drive_random(input int count);
    scenario_t sc;
    int left;
    int seg;
    int pick;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      sc = (pick < 40) ? SC_CRUISE : (pick < 55) ? SC_APPS_SPLIT :
           (pick < 70) ? SC_SENSOR_OUT : (pick < 85) ? SC_BRAKE_OVERLAP : SC_NOISE;
      seg = $urandom_range(1, 16);
      calm = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < seg && left > 0; i++) begin
        send_tick(draw_tick(sc), 1'b0, NO_VERDICT);
        left--;
        if ($urandom_range(0, 63) == 0) drain_results;
      end
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  initial begin
    int stall;
    verdict_t got;
    verdict_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = {torque_cmd, direction_cmd, drive_enable, apps_fault, bse_fault, bppc_fault};
      apps_beats += got.apps;
      bse_beats += got.bse;
      bppc_beats += got.bppc;
      if (expected.size() == 0) begin
        $display("%0t: beat with no expectation, expected none, got torque_cmd %0d",
                 $time, got.torque);
        errors++;
      end else begin
        want = expected.pop_front();
        if (got.torque !== want.torque) report_mismatch("torque_cmd", want.torque, got.torque);
        if (got.fwd !== want.fwd) report_mismatch("direction_cmd", want.fwd, got.fwd);
        if (got.en !== want.en) report_mismatch("drive_enable", want.en, got.en);
        if (got.apps !== want.apps) report_mismatch("apps_fault", want.apps, got.apps);
        if (got.bse !== want.bse) report_mismatch("bse_fault", want.bse, got.bse);
        if (got.bppc !== want.bppc) report_mismatch("bppc_fault", want.bppc, got.bppc);
      end
    end
  end

  initial begin
    // Ticks at reset defaults. Typed results hold only where they follow directly.
    script.push_back({tick_of(8'd1, 8'd1, 8'd128, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0), 1'b1,
                      verdict_of(16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)});
    script.push_back({tick_of(8'd1, 8'd1, 8'd128, 1'b0, 1'b0, 16'd0, 1'b1, 16'd1000), 1'b1,
                      verdict_of(16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)});
    script.push_back({tick_of(8'd254, 8'd254, 8'd128, 1'b0, 1'b0, 16'h7FFF, 1'b1, 16'd0),
                      1'b1, verdict_of(16'd996, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)});
    script.push_back({tick_of(8'd254, 8'd254, 8'd128, 1'b0, 1'b1, 16'h7FFF, 1'b1, 16'd0),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd254, 8'd254, 8'd128, 1'b0, 1'b0, 16'h8000, 1'b1, 16'hFFFF),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd200, 8'd200, 8'd128, 1'b0, 1'b0, 16'd99, 1'b1, 16'd20000),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd200, 8'd200, 8'd128, 1'b0, 1'b0, 16'd100, 1'b1, 16'd20000),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd0, 8'd200, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'hFFFF),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd200, 8'd255, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'hFFFF),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd0, 8'd0, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'd0), 1'b1,
                      verdict_of(16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)});
    script.push_back({tick_of(8'd100, 8'd100, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'hFFFF),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd100, 8'd100, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'hFFFF),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd100, 8'd100, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'd0),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd100, 8'd127, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'd0),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd100, 8'd125, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'd0),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd100, 8'd100, 8'd0, 1'b0, 1'b0, 16'd500, 1'b1, 16'hFFFF),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd100, 8'd100, 8'd255, 1'b0, 1'b0, 16'd500, 1'b1, 16'hFFFF),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd100, 8'd100, 8'd255, 1'b0, 1'b0, 16'd500, 1'b1, 16'd0),
                      1'b1, verdict_of(16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0)});
    script.push_back({tick_of(8'd100, 8'd100, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'hFFFF),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd100, 8'd100, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'hFFFF),
                      1'b0, NO_VERDICT});
    script.push_back({tick_of(8'd66, 8'd66, 8'd128, 1'b1, 1'b0, 16'd500, 1'b1, 16'd0), 1'b1,
                      verdict_of(16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1)});
    script.push_back({tick_of(8'd15, 8'd15, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'd0), 1'b0,
                      NO_VERDICT});
    script.push_back({tick_of(8'd14, 8'd14, 8'd128, 1'b0, 1'b0, 16'd500, 1'b1, 16'd0), 1'b0,
                      NO_VERDICT});
    script.push_back({tick_of(8'd65, 8'd65, 8'd128, 1'b1, 1'b0, 16'd500, 1'b1, 16'd0), 1'b0,
                      NO_VERDICT});
    script.push_back({tick_of(8'd254, 8'd1, 8'd254, 1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF),
                      1'b0, NO_VERDICT});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) send_tick(script[i].stim, script[i].known, script[i].want);
    drive_random(TICKS_PER_PHASE);

    for (int ph = 0; ph < 5; ph++) begin
      drain_results;
      case (ph)
        0: load_settings(0, 0, 0, 0, 0, 32'hFFFF, 0, 32'hFFFF);
        1: load_settings(254, ppt_pkg::TIMER_MAX, ppt_pkg::TIMER_MAX, 254, 254, 0,
                         32'hFFFF, 0);
        4: load_settings(10, 5000, 5000, 128, 30, 40000, 20000, 60000);
        default: load_settings($urandom_range(0, 254), $urandom_range(0, 400000),
                               $urandom_range(0, 400000), $urandom_range(0, 254),
                               $urandom_range(0, 254), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 65535));
      endcase
      drive_random(TICKS_PER_PHASE);
    end

    drain_results;
    repeat (8) @(posedge clk);

    $display("Drove %0d control ticks through %0d register settings with random gaps",
             ticks_sent, settings_used);
    $display("on both sides; faults seen: accelerator %0d, %s %0d, %s %0d.",
             apps_beats, "brake sensor", bse_beats, "brake plausibility", bppc_beats);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
